// ===== src/pst_pkg.sv =====
`default_nettype none

package pst_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 64;

	localparam int ADDR_W     = 48;
	localparam int KEY_W      = 4 * ADDR_W;
	localparam int SESS_W     = 32;
	localparam int LIMIT_W    = 7;
	localparam int STATUS_W   = 2;
	localparam int INDEX_W    = 6;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [LIMIT_W-1:0] RESET_ENTRY_LIMIT   = 7'd50;
	localparam logic [SESS_W-1:0]  RESET_RESTART_ABOVE = 32'd4;
	localparam logic [SESS_W-1:0]  RESET_RESTART_BELOW = 32'd2;

	localparam logic [1:0] REG_ENTRY_LIMIT   = 2'd0;
	localparam logic [1:0] REG_RESTART_ABOVE = 2'd1;
	localparam logic [1:0] REG_RESTART_BELOW = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_UPDATE = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_INSERT = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

	typedef struct packed {
		logic [LIMIT_W-1:0] entry_limit;
		logic [SESS_W-1:0]  restart_above;
		logic [SESS_W-1:0]  restart_below;
	} cfg_t;

	typedef struct packed {
		logic [SESS_W-1:0] prev_packets;
		logic [SESS_W-1:0] cur_packets;
		logic [SESS_W-1:0] prev_session;
		logic [SESS_W-1:0] cur_session;
	} sess_rec_t;

	typedef struct packed {
		logic load_item;
		logic rd_en;
		logic inc_idx;
		logic do_hit;
		logic do_insert;
		logic do_full;
	} cmd_t;

	typedef struct packed {
		logic n_zero;
		logic match;
		logic last;
		logic room;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== src/pst_ram.sv =====
`default_nettype none

module pst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== src/pst_cfg.sv =====
`default_nettype none

module pst_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [pst_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [pst_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [pst_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                  pready,
	output pst_pkg::cfg_t                         cfg
);

	logic [pst_pkg::LIMIT_W-1:0] entry_limit_q;
	logic [pst_pkg::SESS_W-1:0]  restart_above_q;
	logic [pst_pkg::SESS_W-1:0]  restart_below_q;
	logic                        wr_en;
	logic [1:0]                  reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_limit_q   <= pst_pkg::RESET_ENTRY_LIMIT;
			restart_above_q <= pst_pkg::RESET_RESTART_ABOVE;
			restart_below_q <= pst_pkg::RESET_RESTART_BELOW;
		end else if (wr_en) begin
			case (reg_idx)
				pst_pkg::REG_ENTRY_LIMIT: begin
					entry_limit_q <= pwdata[pst_pkg::LIMIT_W-1:0];
				end
				pst_pkg::REG_RESTART_ABOVE: begin
					restart_above_q <= pwdata;
				end
				pst_pkg::REG_RESTART_BELOW: begin
					restart_below_q <= pwdata;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			pst_pkg::REG_ENTRY_LIMIT: begin
				prdata = pst_pkg::APB_DATA_W'(entry_limit_q);
			end
			pst_pkg::REG_RESTART_ABOVE: begin
				prdata = restart_above_q;
			end
			pst_pkg::REG_RESTART_BELOW: begin
				prdata = restart_below_q;
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	assign cfg.entry_limit   = entry_limit_q;
	assign cfg.restart_above = restart_above_q;
	assign cfg.restart_below = restart_below_q;

endmodule

`default_nettype wire

// ===== src/pst_ctrl.sv =====
`default_nettype none

module pst_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_stall,
	input  wire pst_pkg::sts_t sts,
	output pst_pkg::cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_COMP = 4'b0100,
		ST_MISS = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load_item = 1'b1;
					state_d = sts.n_zero ? ST_MISS : ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d = ST_COMP;
			end
			ST_COMP: begin
				if (sts.match) begin
					if (sts.out_free) begin
						cmd.do_hit = 1'b1;
						state_d = ST_IDLE;
					end
				end else if (sts.last) begin
					state_d = ST_MISS;
				end else begin
					cmd.inc_idx = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_MISS: begin
				if (sts.out_free) begin
					cmd.do_insert = sts.room;
					cmd.do_full   = !sts.room;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/pst_dp.sv =====
`default_nettype none

module pst_dp #(
	parameter int TABLE_DEPTH = pst_pkg::DEFAULT_TABLE_DEPTH
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire pst_pkg::cmd_t                     cmd,
	output pst_pkg::sts_t                          sts,
	input  wire pst_pkg::cfg_t                     cfg,
	input  wire logic [pst_pkg::ADDR_W-1:0]        source_addr,
	input  wire logic [pst_pkg::ADDR_W-1:0]        first_hop_addr,
	input  wire logic [pst_pkg::ADDR_W-1:0]        second_hop_addr,
	input  wire logic [pst_pkg::ADDR_W-1:0]        third_hop_addr,
	input  wire logic [pst_pkg::SESS_W-1:0]        session_number,
	input  wire logic                              result_stall,
	output logic                                   result_valid,
	output logic      [pst_pkg::STATUS_W-1:0]      status,
	output logic      [pst_pkg::INDEX_W-1:0]       entry_index
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = (CW > pst_pkg::LIMIT_W) ? CW : pst_pkg::LIMIT_W;
	localparam int RW = $bits(pst_pkg::sess_rec_t);

	logic [pst_pkg::KEY_W-1:0]    key_q;
	logic [pst_pkg::SESS_W-1:0]   sess_q;
	logic [IW-1:0]                idx_q;
	logic [CW-1:0]                count_q;
	logic                         out_valid_q;
	logic [pst_pkg::STATUS_W-1:0] status_q;
	logic [pst_pkg::INDEX_W-1:0]  index_q;

	logic [pst_pkg::KEY_W-1:0]    key_rdata;
	logic [RW-1:0]                rec_rdata;
	pst_pkg::sess_rec_t           rec_rd;
	pst_pkg::sess_rec_t           rec_fresh;
	pst_pkg::sess_rec_t           rec_upd;
	pst_pkg::sess_rec_t           rec_wr;
	logic [IW-1:0]                ins_addr;
	logic [IW-1:0]                rec_waddr;
	logic [EW-1:0]                eff_limit;
	logic                         load_out;

	assign ins_addr = IW'(count_q);

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			key_q  <= {third_hop_addr, second_hop_addr, first_hop_addr, source_addr};
			sess_q <= session_number;
		end
		if (cmd.load_item) begin
			idx_q <= '0;
		end else if (cmd.inc_idx) begin
			idx_q <= idx_q + IW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.do_insert) begin
			count_q <= count_q + CW'(1);
		end
	end

	pst_ram #(
		.WIDTH(pst_pkg::KEY_W),
		.DEPTH(TABLE_DEPTH)
	) u_key_ram (
		.clk  (clk),
		.we   (cmd.do_insert),
		.waddr(ins_addr),
		.wdata(key_q),
		.re   (cmd.rd_en),
		.raddr(idx_q),
		.rdata(key_rdata)
	);

	pst_ram #(
		.WIDTH(RW),
		.DEPTH(TABLE_DEPTH)
	) u_sess_ram (
		.clk  (clk),
		.we   (cmd.do_insert || cmd.do_hit),
		.waddr(rec_waddr),
		.wdata(rec_wr),
		.re   (cmd.rd_en),
		.raddr(idx_q),
		.rdata(rec_rdata)
	);

	assign rec_rd = rec_rdata;

	always_comb begin
		rec_fresh.cur_session  = sess_q;
		rec_fresh.prev_session = '0;
		rec_fresh.cur_packets  = pst_pkg::SESS_W'(1);
		rec_fresh.prev_packets = '0;

		if (rec_rd.cur_session > cfg.restart_above && sess_q < cfg.restart_below) begin
			rec_upd = rec_fresh;
		end else if (sess_q > rec_rd.cur_session) begin
			rec_upd.prev_session = rec_rd.cur_session;
			rec_upd.prev_packets = rec_rd.cur_packets;
			rec_upd.cur_session  = sess_q;
			rec_upd.cur_packets  = pst_pkg::SESS_W'(1);
		end else begin
			rec_upd = rec_rd;
			rec_upd.cur_packets = rec_rd.cur_packets + pst_pkg::SESS_W'(1);
		end

		rec_wr    = cmd.do_hit ? rec_upd : rec_fresh;
		rec_waddr = cmd.do_hit ? idx_q : ins_addr;
	end

	assign eff_limit = (EW'(cfg.entry_limit) > EW'(TABLE_DEPTH)) ?
		EW'(TABLE_DEPTH) : EW'(cfg.entry_limit);

	assign load_out = cmd.do_hit || cmd.do_insert || cmd.do_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_hit) begin
			status_q <= pst_pkg::STATUS_UPDATE;
			index_q  <= pst_pkg::INDEX_W'(idx_q);
		end else if (cmd.do_insert) begin
			status_q <= pst_pkg::STATUS_INSERT;
			index_q  <= pst_pkg::INDEX_W'(count_q);
		end else if (cmd.do_full) begin
			status_q <= pst_pkg::STATUS_FULL;
			index_q  <= '0;
		end
	end

	assign sts.n_zero   = (count_q == '0);
	assign sts.match    = (key_rdata == key_q);
	assign sts.last     = ((CW'(idx_q) + CW'(1)) == count_q);
	assign sts.room     = (EW'(count_q) < eff_limit);
	assign sts.out_free = !out_valid_q || !result_stall;

	assign result_valid = out_valid_q;
	assign status       = status_q;
	assign entry_index  = index_q;

endmodule

`default_nettype wire

// ===== src/path_session_table.sv =====
// Exact-match table of packet paths with per-path session accounting.
// An item enters on the item channel (item_valid/item_stall): four 48-bit
// addresses and a session number. One result leaves on the result channel
// (result_valid/result_stall): a status and the entry index.
// The controller walks the stored entries one at a time through the key RAM,
// with a read state and then a compare state for each entry. It returns to
// idle as the result is loaded and takes the next item in the following cycle.
// On a hit the session record of the entry is read with the key, then updated
// and written back in the compare state; on a miss a new entry is appended if
// the limit allows. The result sits in an output register; while result_stall
// is high it holds, and the controller waits before loading a new result, with
// item_stall high. Reset empties the table and loads the register defaults;
// RAM contents are not cleared. Registers are to be written through the APB
// port only while the block is idle; the block itself does not enforce this.
`default_nettype none

module path_session_table #(
	parameter int TABLE_DEPTH = pst_pkg::DEFAULT_TABLE_DEPTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [pst_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [pst_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [pst_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                 pready,
	input  wire logic                            item_valid,
	output logic                                 item_stall,
	input  wire logic [pst_pkg::ADDR_W-1:0]      source_addr,
	input  wire logic [pst_pkg::ADDR_W-1:0]      first_hop_addr,
	input  wire logic [pst_pkg::ADDR_W-1:0]      second_hop_addr,
	input  wire logic [pst_pkg::ADDR_W-1:0]      third_hop_addr,
	input  wire logic [pst_pkg::SESS_W-1:0]      session_number,
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output logic      [pst_pkg::STATUS_W-1:0]    status,
	output logic      [pst_pkg::INDEX_W-1:0]     entry_index
);

	pst_pkg::cfg_t cfg;
	pst_pkg::cmd_t cmd;
	pst_pkg::sts_t sts;

	pst_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	pst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	pst_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg            (cfg),
		.source_addr    (source_addr),
		.first_hop_addr (first_hop_addr),
		.second_hop_addr(second_hop_addr),
		.third_hop_addr (third_hop_addr),
		.session_number (session_number),
		.result_stall   (result_stall),
		.result_valid   (result_valid),
		.status         (status),
		.entry_index    (entry_index)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("block took a second transaction while one was in work");

	a_result_needs_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result appeared without a transaction in work");

	a_full_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == pst_pkg::STATUS_FULL |-> entry_index == '0)
		else $error("table full result carries a nonzero index");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (status == pst_pkg::STATUS_UPDATE ||
			status == pst_pkg::STATUS_INSERT || status == pst_pkg::STATUS_FULL))
		else $error("result status is not a defined code");

endmodule

`default_nettype wire

// ===== tb/sv/path_session_table_checker.sv =====
`timescale 1ns / 100ps

module path_session_table_checker
	import pst_pkg::*;
#(
	parameter int DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic                  pready,
	input  logic                  item_valid,
	input  logic                  item_stall,
	input  logic [ADDR_W-1:0]     source_addr,
	input  logic [ADDR_W-1:0]     first_hop_addr,
	input  logic [ADDR_W-1:0]     second_hop_addr,
	input  logic [ADDR_W-1:0]     third_hop_addr,
	input  logic [SESS_W-1:0]     session_number,
	input  logic                  result_valid,
	input  logic                  result_stall,
	input  logic [STATUS_W-1:0]   status,
	input  logic [INDEX_W-1:0]    entry_index,
	output int                    error_count,
	output int                    pending,
	output int                    update_count,
	output int                    insert_count,
	output int                    full_count
);

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0]  index;
	} outcome_t;

	logic [KEY_W-1:0]   path_key  [DEPTH];
	logic [SESS_W-1:0]  cur_sess  [DEPTH];
	logic [SESS_W-1:0]  prev_sess [DEPTH];
	logic [SESS_W-1:0]  cur_pkts  [DEPTH];
	logic [SESS_W-1:0]  prev_pkts [DEPTH];
	int unsigned        path_count;
	logic [LIMIT_W-1:0] cfg_limit;
	logic [SESS_W-1:0]  cfg_above;
	logic [SESS_W-1:0]  cfg_below;
	outcome_t           outcome_q [$];

	function automatic void open_session(input int idx, input logic [SESS_W-1:0] sess);
		cur_sess[idx]  = sess;
		prev_sess[idx] = '0;
		cur_pkts[idx]  = 1;
		prev_pkts[idx] = '0;
	endfunction

	function automatic outcome_t account_packet(input logic [KEY_W-1:0] key,
			input logic [SESS_W-1:0] sess);
		outcome_t    res;
		int unsigned lim;
		int          hit;
		hit = -1;
		lim = (cfg_limit < DEPTH) ? cfg_limit : DEPTH;
		for (int i = 0; i < path_count; i++) begin
			if (hit < 0 && path_key[i] == key)
				hit = i;
		end
		if (hit >= 0) begin
			if (cur_sess[hit] > cfg_above && sess < cfg_below) begin
				open_session(hit, sess);
			end else if (sess > cur_sess[hit]) begin
				prev_sess[hit] = cur_sess[hit];
				prev_pkts[hit] = cur_pkts[hit];
				cur_sess[hit]  = sess;
				cur_pkts[hit]  = 1;
			end else begin
				cur_pkts[hit] = cur_pkts[hit] + 1;
			end
			res.status = STATUS_UPDATE;
			res.index  = INDEX_W'(hit);
		end else if (path_count < lim) begin
			path_key[path_count] = key;
			open_session(path_count, sess);
			res.status = STATUS_INSERT;
			res.index  = INDEX_W'(path_count);
			path_count++;
		end else begin
			res.status = STATUS_FULL;
			res.index  = '0;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int       errs;
		outcome_t want;
		errs = 0;
		if (!arst_n) begin
			path_count = 0;
			cfg_limit  = RESET_ENTRY_LIMIT;
			cfg_above  = RESET_RESTART_ABOVE;
			cfg_below  = RESET_RESTART_BELOW;
			outcome_q.delete();
			error_count  <= 0;
			pending      <= 0;
			update_count <= 0;
			insert_count <= 0;
			full_count   <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (outcome_q.size() == 0) begin
					$error("result transaction with nothing expected: status %0d, entry_index %0d",
						status, entry_index);
					errs++;
				end else begin
					want = outcome_q.pop_front();
					if (status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d", want.status, status);
						errs++;
					end
					if (entry_index !== want.index) begin
						$error("entry_index mismatch: expected %0d, actual %0d",
							want.index, entry_index);
						errs++;
					end
					case (want.status)
						STATUS_UPDATE: update_count <= update_count + 1;
						STATUS_INSERT: insert_count <= insert_count + 1;
						default:       full_count   <= full_count + 1;
					endcase
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_ADDR_W-1:2])
					REG_ENTRY_LIMIT:   cfg_limit = pwdata[LIMIT_W-1:0];
					REG_RESTART_ABOVE: cfg_above = pwdata[SESS_W-1:0];
					REG_RESTART_BELOW: cfg_below = pwdata[SESS_W-1:0];
					default: ;
				endcase
			end
			if (item_valid && !item_stall) begin
				outcome_q.push_back(account_packet({third_hop_addr, second_hop_addr,
					first_hop_addr, source_addr}, session_number));
			end
			pending     <= outcome_q.size();
			error_count <= error_count + errs;
		end
	end

endmodule

// ===== tb/sv/tb_path_session_table.sv =====
`timescale 1ns / 100ps

module tb_path_session_table;
	import pst_pkg::*;

	typedef struct {
		logic [ADDR_W-1:0] source;
		logic [ADDR_W-1:0] hop1;
		logic [ADDR_W-1:0] hop2;
		logic [ADDR_W-1:0] hop3;
		logic [SESS_W-1:0] last_session;
	} path_t;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 2 * DEFAULT_TABLE_DEPTH + 12;
	localparam int SEGMENT_ITEMS  = 75;
	localparam int POOL_MAX       = 80;

	logic                  clk             = 1'b0;
	logic                  arst_n          = 1'b0;
	logic                  psel            = 1'b0;
	logic                  penable         = 1'b0;
	logic                  pwrite          = 1'b0;
	logic [APB_ADDR_W-1:0] paddr           = '0;
	logic [APB_DATA_W-1:0] pwdata          = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  item_valid      = 1'b0;
	logic                  item_stall;
	logic [ADDR_W-1:0]     source_addr     = '0;
	logic [ADDR_W-1:0]     first_hop_addr  = '0;
	logic [ADDR_W-1:0]     second_hop_addr = '0;
	logic [ADDR_W-1:0]     third_hop_addr  = '0;
	logic [SESS_W-1:0]     session_number  = '0;
	logic                  result_valid;
	logic                  result_stall    = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [INDEX_W-1:0]    entry_index;

	int error_count;
	int pending;
	int update_count;
	int insert_count;
	int full_count;

	int                send_idle_pct  = 0;
	int                recv_stall_pct = 0;
	int                quiet_cycles   = 0;
	int                items_sent     = 0;
	int                settings_used  = 0;
	logic [SESS_W-1:0] above_now      = RESET_RESTART_ABOVE;
	logic [SESS_W-1:0] below_now      = RESET_RESTART_BELOW;
	path_t             path_pool [$];

	always #10 clk = ~clk;

	path_session_table DUT (.*);

	path_session_table_checker u_path_check (.*);

	always @(posedge clk)
		result_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || psel || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
				WATCHDOG_LIMIT, pending);
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [LIMIT_W-1:0] limit, input logic [SESS_W-1:0] above,
			input logic [SESS_W-1:0] below);
		wait_drained();
		reg_write(REG_ENTRY_LIMIT, APB_DATA_W'(limit));
		reg_write(REG_RESTART_ABOVE, above);
		reg_write(REG_RESTART_BELOW, below);
		above_now = above;
		below_now = below;
		settings_used++;
	endtask

	task automatic send_path(input path_t p, input logic [SESS_W-1:0] sess);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid      <= 1'b1;
		source_addr     <= p.source;
		first_hop_addr  <= p.hop1;
		second_hop_addr <= p.hop2;
		third_hop_addr  <= p.hop3;
		session_number  <= sess;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		items_sent++;
	endtask

	function automatic logic [ADDR_W-1:0] rand_addr();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			default: return ADDR_W'({$urandom, $urandom});
		endcase
	endfunction

	function automatic path_t fresh_path();
		path_t p;
		p.source       = rand_addr();
		p.hop1         = rand_addr();
		p.hop2         = rand_addr();
		p.hop3         = rand_addr();
		p.last_session = '0;
		return p;
	endfunction

	function automatic logic [SESS_W-1:0] rand_session(input logic [SESS_W-1:0] last);
		case ($urandom_range(8))
			0:       return '0;
			1:       return last + 1;
			2:       return last;
			3:       return last - 1;
			4:       return below_now - 1;
			5:       return above_now + 1;
			6:       return SESS_W'($urandom_range(15));
			7:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// Mostly paths already in the table with sessions near the last one sent,
	// plus new paths and single-bit near misses of known paths.
	task automatic random_traffic(input int count);
		path_t             p;
		int                pick;
		int                kind;
		int                bit_idx;
		logic [SESS_W-1:0] sess;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(39) == 0)
				wait_drained();
			kind = $urandom_range(99);
			if (path_pool.size() == 0 || kind < 25) begin
				p = fresh_path();
				sess = rand_session(p.last_session);
				p.last_session = sess;
				if (path_pool.size() < POOL_MAX)
					path_pool.push_back(p);
			end else begin
				pick = $urandom_range(path_pool.size() - 1);
				p = path_pool[pick];
				sess = rand_session(p.last_session);
				if (kind < 33) begin
					bit_idx = $urandom_range(ADDR_W - 1);
					case ($urandom_range(3))
						0:       p.source[bit_idx] = ~p.source[bit_idx];
						1:       p.hop1[bit_idx]   = ~p.hop1[bit_idx];
						2:       p.hop2[bit_idx]   = ~p.hop2[bit_idx];
						default: p.hop3[bit_idx]   = ~p.hop3[bit_idx];
					endcase
				end else begin
					path_pool[pick].last_session = sess;
				end
			end
			send_path(p, sess);
		end
	endtask

	initial begin
		path_t zero_path;
		path_t ones_path;
		path_t near_path;

		zero_path = '{'0, '0, '0, '0, '0};
		ones_path = '{'1, '1, '1, '1, '1};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct  = 18;
		recv_stall_pct = 61;

		// With a limit of zero nothing may be created.
		configure('0, RESET_RESTART_ABOVE, RESET_RESTART_BELOW);
		send_path(zero_path, '0);
		send_path(ones_path, '1);
		send_path(fresh_path(), 32'd7);

		// Three entries: insert, count, roll, restart, near miss and table full.
		configure(7'd3, RESET_RESTART_ABOVE, RESET_RESTART_BELOW);
		send_path(zero_path, '0);
		send_path(zero_path, '0);
		send_path(zero_path, 32'd10);
		send_path(zero_path, 32'd1);
		send_path(zero_path, 32'd3);
		send_path(ones_path, '1);
		send_path(ones_path, '0);
		send_path(ones_path, '1);
		send_path(ones_path, '1);
		near_path = zero_path;
		near_path.hop3[ADDR_W-1] = 1'b1;
		send_path(near_path, 32'd5);
		near_path = zero_path;
		near_path.source[0] = 1'b1;
		send_path(near_path, 32'd5);
		send_path(zero_path, 32'd5);
		zero_path.last_session = 32'd5;
		ones_path.last_session = '1;
		path_pool.push_back(zero_path);
		path_pool.push_back(ones_path);
		path_pool.push_back(near_path);

		configure(RESET_ENTRY_LIMIT, RESET_RESTART_ABOVE, RESET_RESTART_BELOW);
		random_traffic(SEGMENT_ITEMS);
		configure('1, '0, '1);
		random_traffic(SEGMENT_ITEMS);

		send_idle_pct  = 61;
		recv_stall_pct = 18;
		configure(7'd20, '1, '0);
		random_traffic(SEGMENT_ITEMS);
		configure(7'd64, $urandom_range(64), $urandom_range(64));
		random_traffic(SEGMENT_ITEMS);

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		configure(7'd100, 32'd100, 32'd50);
		random_traffic(SEGMENT_ITEMS);
		configure(7'd64, '0, '0);
		random_traffic(SEGMENT_ITEMS);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d path transactions under %0d register settings.",
			items_sent, settings_used);
		$display("Results: %0d updates, %0d inserts, %0d table-full drops, %0d errors.",
			update_count, insert_count, full_count, error_count);
		if (error_count == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/pst_pkg.sv
src/pst_ram.sv
src/pst_cfg.sv
src/pst_ctrl.sv
src/pst_dp.sv
src/path_session_table.sv
tb/sv/path_session_table_checker.sv
tb/sv/tb_path_session_table.sv
